>>> hw/rtl/lrrd_pkg.sv
package lrrd_pkg;

  // Generator constants (minimal standard multiplier, Mersenne prime modulus).
  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;

  // Reset value of the generator state.
  localparam logic [30:0] STATE_RESET = 31'd1;

  // Function codes carried on in_func.
  localparam logic [1:0] FUNC_UNIFORM   = 2'd0;
  localparam logic [1:0] FUNC_RANGE     = 2'd1;
  localparam logic [1:0] FUNC_BERNOULLI = 2'd2;
  localparam logic [1:0] FUNC_SEED      = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture input word, start the state multiply
    logic reduce;  // fold product into the new state, or load the seed
    logic scale;   // span multiply and Q0.32 fraction
    logic finish;  // quotient, final fields into the output register
  } cmd_t;

endpackage

>>> hw/rtl/lehmer_rng_with_range_draws.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   func, seed_value, range_low, range_high,
//                                           success_prob
// out_     output     out_valid / out_stall raw_state, uniform_fraction, int_value,
//                                           success, range_error
//
// Each word is handled in steps: accept with the state multiply, fold into the new
// state, span multiply, quotient into the output register.
// The next word waits until the last is done: its draw needs the single state register.
// Reset (rst_n low, synchronous) sets the generator state to 1, empties the
// output register and returns the controller to idle.
// A stalled result holds in the output register; the next word is still taken
// and waits in its last step until the result is taken.
module lehmer_rng_with_range_draws (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [30:0]         in_seed_value,
  input  logic signed [31:0]  in_range_low,
  input  logic signed [31:0]  in_range_high,
  input  logic [32:0]         in_success_prob,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [30:0]         out_raw_state,
  output logic [31:0]         out_uniform_fraction,
  output logic signed [31:0]  out_int_value,
  output logic                out_success,
  output logic                out_range_error
);

  lrrd_pkg::cmd_t cmd;

  // Sequencer: handshakes on both channels, one step command per cycle unless held by a stalled result.
  lrrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: generator state, the two multipliers, Mersenne folds and the
  // output register.
  lrrd_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_func              (in_func),
    .in_seed_value        (in_seed_value),
    .in_range_low         (in_range_low),
    .in_range_high        (in_range_high),
    .in_success_prob      (in_success_prob),
    .out_raw_state        (out_raw_state),
    .out_uniform_fraction (out_uniform_fraction),
    .out_int_value        (out_int_value),
    .out_success          (out_success),
    .out_range_error      (out_range_error)
  );

  // Block the next word for the steps that follow an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // The state never equals the modulus.
  a_state_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_raw_state != lrrd_pkg::LCG_MOD)
    else $error("raw state not reduced");

  // A Bernoulli hit carries no integer draw and no range flag.
  a_success_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_int_value == 32'sd0 && !out_range_error)
    else $error("success mixed with integer draw fields");

endmodule

>>> hw/rtl/lrrd_ctrl.sv
module lrrd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lrrd_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RED   = 4'b0010,
    S_SCALE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_finish;

  assign can_finish = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result is still stalled
        if (can_finish) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/lrrd_datapath.sv
module lrrd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lrrd_pkg::cmd_t      cmd,
  input  logic [1:0]          in_func,
  input  logic [30:0]         in_seed_value,
  input  logic signed [31:0]  in_range_low,
  input  logic signed [31:0]  in_range_high,
  input  logic [32:0]         in_success_prob,
  output logic [30:0]         out_raw_state,
  output logic [31:0]         out_uniform_fraction,
  output logic signed [31:0]  out_int_value,
  output logic                out_success,
  output logic                out_range_error
);

  logic [30:0] state_r, state_nxt;
  logic [1:0]  func_r;
  logic [30:0] seed_r;
  logic [31:0] low_r;
  logic [32:0] prob_r;
  logic [32:0] span_r;
  logic        rerr_r;
  logic [45:0] mprod_r;
  logic [62:0] sprod_r;
  logic [31:0] frac_r, frac_nxt;

  logic [32:0] diff;
  logic [31:0] fold;
  logic [31:0] dbl;
  logic [31:0] quo_a;
  logic [32:0] quo_t;
  logic [31:0] quo_r;
  logic [31:0] quo;
  logic [31:0] quo_sel;
  logic [31:0] int_sum;

  // span = high - low + 1, negative difference flags a reversed range
  assign diff = {in_range_high[31], in_range_high} - {in_range_low[31], in_range_low};

  // Mersenne fold: p mod (2^31-1) = p[45:31] + p[30:0], one correction
  assign fold = {17'd0, mprod_r[45:31]} + {1'b0, mprod_r[30:0]};

  always_comb begin
    if (func_r == lrrd_pkg::FUNC_SEED) begin
      state_nxt = (seed_r == lrrd_pkg::LCG_MOD) ? 31'd0 : seed_r;
    end else if (fold >= {1'b0, lrrd_pkg::LCG_MOD}) begin
      state_nxt = 31'(fold - {1'b0, lrrd_pkg::LCG_MOD});
    end else begin
      state_nxt = fold[30:0];
    end
  end

  // s*2^32/M = 2s + 2s/M, and 2s/M is below two
  assign dbl      = {state_r, 1'b0};
  assign frac_nxt = dbl + {31'd0, (dbl >= {1'b0, lrrd_pkg::LCG_MOD})};

  // floor(P/M) with P = a*2^31 + b: a + floor((a+b)/M), folded twice
  assign quo_a   = sprod_r[62:31];
  assign quo_t   = {1'b0, quo_a} + {2'd0, sprod_r[30:0]};
  assign quo_r   = {30'd0, quo_t[32:31]} + {1'b0, quo_t[30:0]};
  assign quo     = quo_a + {30'd0, quo_t[32:31]}
                 + {31'd0, (quo_r >= {1'b0, lrrd_pkg::LCG_MOD})};
  // a full 2^32 span scales exactly like the fraction
  assign quo_sel = span_r[32] ? frac_r : quo;
  assign int_sum = low_r + quo_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrrd_pkg::STATE_RESET;
    end else if (cmd.reduce) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      seed_r  <= in_seed_value;
      low_r   <= in_range_low;
      prob_r  <= in_success_prob;
      rerr_r  <= diff[32];
      span_r  <= diff + 33'd1;
      mprod_r <= 46'(state_r) * 46'(lrrd_pkg::LCG_MULT);
    end
    if (cmd.scale) begin
      sprod_r <= 63'(state_r) * 63'(span_r[31:0]);
      frac_r  <= frac_nxt;
    end
    if (cmd.finish) begin
      out_raw_state        <= state_r;
      out_uniform_fraction <= frac_r;
      out_success          <= (func_r == lrrd_pkg::FUNC_BERNOULLI)
                              && ({1'b0, frac_r} < prob_r);
      out_range_error      <= (func_r == lrrd_pkg::FUNC_RANGE) && rerr_r;
      if (func_r != lrrd_pkg::FUNC_RANGE) begin
        out_int_value <= '0;
      end else if (rerr_r) begin
        out_int_value <= $signed(low_r);
      end else begin
        out_int_value <= $signed(int_sum);
      end
    end
  end

endmodule
